### hdl/npm_pkg.sv
// ----------------------------------------------------------------------------
// npm_pkg
// Shared types and constants for the nearest point matcher.
// ----------------------------------------------------------------------------
package npm_pkg;

    localparam int IDX_W   = 10;  // reported target index width
    localparam int DIST_W  = 33;  // reported squared distance width
    localparam int LIMIT_W = 32;  // squared match limit width
    localparam int CFG_W   = 16;  // configuration data width

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    localparam logic REG_MAX_DIST = 1'b0;
    localparam logic REG_MATCH_EP = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic do_clear;
        logic do_load;
        logic start_query;
        logic issue;
        logic load_out;
    } t_ctrl;

    typedef struct packed {
        logic count_zero;
        logic scan_allowed;
        logic last_issue;
        logic pipe_empty;
        logic out_free;
    } t_stat;

endpackage

### hdl/npm_ram.sv
// ----------------------------------------------------------------------------
// npm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module npm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/npm_ctrl.sv
// ----------------------------------------------------------------------------
// npm_ctrl
// Sequencer: takes input words, runs the target scan, hands off the result.
// ----------------------------------------------------------------------------
module npm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_cmd,
    input  npm_pkg::t_stat i_stat,
    output npm_pkg::t_ctrl o_ctrl
);
    import npm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_cmd == CMD_QUERY) begin
                    if (i_stat.scan_allowed && !i_stat.count_zero) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.do_clear    = accept && i_cmd == CMD_CLEAR;
                o_ctrl.do_load     = accept && i_cmd == CMD_LOAD;
                o_ctrl.start_query = accept && i_cmd == CMD_QUERY;
            end
            S_SCAN:   o_ctrl.issue    = 1'b1;
            S_DRAIN:  o_ctrl = '0;
            S_RESULT: o_ctrl.load_out = i_stat.out_free;
            default:  o_ctrl = '0;
        endcase
    end

    a_issue_needs_targets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.issue |-> !i_stat.count_zero)
        else $error("scan issued on an empty store");

    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load_out |-> i_stat.pipe_empty)
        else $error("result loaded with distances still in flight");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && !i_stat.out_free) |=> r_state == S_RESULT)
        else $error("result dropped while output busy");

endmodule

### hdl/npm_dpath.sv
// ----------------------------------------------------------------------------
// npm_dpath
// Target store, distance pipeline, best-match tracker and output register.
// ----------------------------------------------------------------------------
module npm_dpath #(
    parameter int MAX_TARGETS = 1024,
    parameter int COORD_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [npm_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    input  logic                                i_scan_first,
    input  logic                                i_scan_last,
    input  npm_pkg::t_ctrl                      i_ctrl,
    output npm_pkg::t_stat                      o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_matched,
    output logic [npm_pkg::IDX_W-1:0]           o_target_index,
    output logic [npm_pkg::DIST_W-1:0]          o_distance_sq
);
    import npm_pkg::*;

    localparam int IW   = $clog2(MAX_TARGETS);
    localparam int CW   = $clog2(MAX_TARGETS + 1);
    localparam int SW   = 2 * COORD_BITS + 1;
    localparam int CMPW = (SW > LIMIT_W) ? SW : LIMIT_W;

    function automatic logic [COORD_BITS-1:0] f_abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] ea;
        logic signed [COORD_BITS:0] eb;
        logic signed [COORD_BITS:0] d;
        ea = {a[COORD_BITS-1], a};
        eb = {b[COORD_BITS-1], b};
        d  = (ea >= eb) ? (ea - eb) : (eb - ea);
        return d[COORD_BITS-1:0];
    endfunction

    // configuration
    logic [CFG_W-1:0]   r_max_dist;
    logic               r_match_ep;
    logic [LIMIT_W-1:0] r_limit;

    // store
    logic [CW-1:0]             r_count;
    logic [2*COORD_BITS-1:0]   ram_rdata;
    logic                      ram_we;

    // query point
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;

    // pipeline
    logic [IW-1:0]           r_addr;
    logic                    r_rd_vld;
    logic [IW-1:0]           r_rd_idx;
    logic                    r_s1_vld;
    logic [IW-1:0]           r_s1_idx;
    logic [COORD_BITS-1:0]   r_dx;
    logic [COORD_BITS-1:0]   r_dy;
    logic                    r_s2_vld;
    logic [IW-1:0]           r_s2_idx;
    logic [2*COORD_BITS-1:0] r_sx;
    logic [2*COORD_BITS-1:0] r_sy;

    // best match
    logic               r_found;
    logic [LIMIT_W-1:0] r_best_d;
    logic [IW-1:0]      r_best_idx;

    // output word
    logic              r_o_valid;
    logic              r_o_matched;
    logic [IDX_W-1:0]  r_o_idx;
    logic [DIST_W-1:0] r_o_dist;

    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic [SW-1:0]                d_sum;
    logic [CMPW-1:0]              d_ext;
    logic                         better;
    logic                         at_end_target;
    logic                         final_match;
    logic [IW+IDX_W-1:0]          idx_ext;

    assign ram_we = i_ctrl.do_load && (r_count < CW'(MAX_TARGETS));

    npm_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_TARGETS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_y = ram_rdata[COORD_BITS-1:0];

    assign d_sum  = {1'b0, r_sx} + {1'b0, r_sy};
    assign d_ext  = CMPW'(d_sum);
    assign better = r_s2_vld && (d_ext < CMPW'(r_limit))
                    && (!r_found || d_ext < CMPW'(r_best_d));

    assign at_end_target = (r_best_idx == '0) || (CW'(r_best_idx) + CW'(1) == r_count);
    assign final_match   = r_found && (r_match_ep || !at_end_target);
    assign idx_ext       = {{IDX_W{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= CFG_W'(512);
            r_match_ep <= 1'b1;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_DIST: r_max_dist <= i_cfg_data;
                    REG_MATCH_EP: r_match_ep <= i_cfg_data[0];
                    default:      r_max_dist <= r_max_dist;
                endcase
            end

            if (i_ctrl.do_clear) begin
                r_count <= '0;
            end else if (ram_we) begin
                r_count <= r_count + CW'(1);
            end

            r_rd_vld <= i_ctrl.issue;
            r_s1_vld <= r_rd_vld;
            r_s2_vld <= r_s1_vld;

            if (i_ctrl.start_query) begin
                r_found <= 1'b0;
            end else if (better) begin
                r_found <= 1'b1;
            end

            if (i_ctrl.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= {16'd0, r_max_dist} * {16'd0, r_max_dist};

        if (i_ctrl.start_query) begin
            r_qx   <= i_point_x;
            r_qy   <= i_point_y;
            r_addr <= '0;
        end else if (i_ctrl.issue) begin
            r_addr <= r_addr + IW'(1);
        end

        r_rd_idx <= r_addr;
        r_s1_idx <= r_rd_idx;
        r_dx     <= f_abs_diff(r_qx, rd_x);
        r_dy     <= f_abs_diff(r_qy, rd_y);
        r_s2_idx <= r_s1_idx;
        r_sx     <= {{COORD_BITS{1'b0}}, r_dx} * {{COORD_BITS{1'b0}}, r_dx};
        r_sy     <= {{COORD_BITS{1'b0}}, r_dy} * {{COORD_BITS{1'b0}}, r_dy};

        // a qualifying distance is below the limit, so it fits the limit width
        if (better) begin
            r_best_d   <= LIMIT_W'(d_ext);
            r_best_idx <= r_s2_idx;
        end

        if (i_ctrl.load_out) begin
            r_o_matched <= final_match;
            r_o_idx     <= final_match ? idx_ext[IDX_W-1:0] : '0;
            r_o_dist    <= final_match ? DIST_W'(r_best_d) : '0;
        end
    end

    assign o_stat.count_zero   = (r_count == '0);
    assign o_stat.scan_allowed = r_match_ep || (!i_scan_first && !i_scan_last);
    assign o_stat.last_issue   = (CW'(r_addr) + CW'(1) == r_count);
    assign o_stat.pipe_empty   = !(r_rd_vld || r_s1_vld || r_s2_vld);
    assign o_stat.out_free     = !r_o_valid || i_out_ready;

    assign o_out_valid    = r_o_valid;
    assign o_matched      = r_o_matched;
    assign o_target_index = r_o_idx;
    assign o_distance_sq  = r_o_dist;

    // best match is only meaningful while its query result is being loaded
    a_best_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.load_out && r_found) |-> (r_best_d < r_limit))
        else $error("best match not below limit");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TARGETS))
        else $error("target count beyond store depth");

    a_best_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.load_out && r_found) |-> (CW'(r_best_idx) < r_count))
        else $error("best index outside loaded targets");

endmodule

### hdl/nearest_point_matcher.sv
// ----------------------------------------------------------------------------
// nearest_point_matcher
// Nearest stored target search for 2D query points.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one word per command:
//   clear the store, load one target point, or query a point.
// Clear and load finish in the accepting cycle and give no result word.
// A query gives exactly one result word on the output channel
// (o_out_valid / i_out_ready): match flag, target index, squared distance.
// A query that scans the stored targets reads the store one target a cycle
// through its single read port, then three pipeline stages (difference,
// square, compare) drain before the result.
// A query with no targets, or an endpoint query with endpoint matching
// off, returns unmatched without a scan.
// The result sits in an output register; the next command word is taken
// while it waits. If the receiver stalls, a following query completes its
// scan and then holds until the previous result word is taken.
// Reset empties the store (count only), restores the maximum match distance
// to 512 and enables endpoint matching. Configuration writes are registered
// and are made while the block is idle: the user is bound, the block does not enforce it.
// ----------------------------------------------------------------------------
module nearest_point_matcher #(
    parameter int MAX_TARGETS = 1024,
    parameter int COORD_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [npm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_cmd,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    input  logic                          i_scan_first,
    input  logic                          i_scan_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_matched,
    output logic [npm_pkg::IDX_W-1:0]     o_target_index,
    output logic [npm_pkg::DIST_W-1:0]    o_distance_sq
);
    import npm_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    npm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    npm_dpath #(
        .MAX_TARGETS (MAX_TARGETS),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_scan_first   (i_scan_first),
        .i_scan_last    (i_scan_last),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_matched      (o_matched),
        .o_target_index (o_target_index),
        .o_distance_sq  (o_distance_sq)
    );

endmodule
